// ===== rtl/lpnl_pkg.sv =====
// Package with the shared constants, types and helper functions of the name lookup block.
package lpnl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NAME_CHARS  = 5;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W   = $clog2(NAME_CHARS + 1);
    localparam int NAME_W  = 8 * NAME_CHARS;
    localparam int VALUE_W = 64;
    localparam int ENTRY_W = VALUE_W + LEN_W + NAME_W;

    localparam int F_IDX_W   = 6;
    localparam int F_CHARS_W = 40;
    localparam int F_LEN_W   = 3;
    localparam int CFG_W     = 7;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic             load_wr;
        logic             start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             cmp_en;
        logic [IDX_W-1:0] cmp_idx;
        logic             out_load;
    } t_cmd;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [F_LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (int'(len) > NAME_CHARS) begin
            res = LEN_W'(NAME_CHARS);
        end else begin
            res = LEN_W'(len);
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] prefix_len(input logic [NAME_W-1:0] a,
                                                    input logic [NAME_W-1:0] b,
                                                    input logic [LEN_W-1:0]  lim);
        logic [LEN_W-1:0] cnt;
        logic             run;
        cnt = '0;
        run = 1'b1;
        for (int j = 0; j < NAME_CHARS; j++) begin
            if (run && (j < int'(lim)) && (a[8*j +: 8] == b[8*j +: 8])) begin
                cnt = cnt + LEN_W'(1);
            end else begin
                run = 1'b0;
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/lpnl_if.sv =====
// Handshake interfaces for the request and response channels of the name lookup block.
interface lpnl_req_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [lpnl_pkg::F_IDX_W-1:0]     entry_index;
    logic [lpnl_pkg::F_CHARS_W-1:0]   name_chars;
    logic [lpnl_pkg::F_LEN_W-1:0]     name_length;
    logic [lpnl_pkg::VALUE_W-1:0]     value_bits;

    modport source (output valid, operation, entry_index, name_chars, name_length,
                    value_bits, input ready);
    modport sink (input valid, operation, entry_index, name_chars, name_length,
                  value_bits, output ready);
endinterface

interface lpnl_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [lpnl_pkg::VALUE_W-1:0]     value_out;
    logic [lpnl_pkg::F_IDX_W-1:0]     winner_index;
    logic [lpnl_pkg::F_LEN_W-1:0]     matched_length;

    modport source (output valid, found, value_out, winner_index, matched_length,
                    input ready);
    modport sink (input valid, found, value_out, winner_index, matched_length,
                  output ready);
endinterface

// ===== rtl/lpnl_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module lpnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lpnl_dp.sv =====
// Datapath of the name lookup: entry table, query registers, best-match tracking and result.
module lpnl_dp (
    input  logic                             i_clk,
    input  lpnl_pkg::t_cmd                   i_cmd,
    input  logic [lpnl_pkg::F_IDX_W-1:0]     i_entry_index,
    input  logic [lpnl_pkg::F_CHARS_W-1:0]   i_name_chars,
    input  logic [lpnl_pkg::F_LEN_W-1:0]     i_name_length,
    input  logic [lpnl_pkg::VALUE_W-1:0]     i_value_bits,
    output logic                             o_found,
    output logic [lpnl_pkg::VALUE_W-1:0]     o_value_out,
    output logic [lpnl_pkg::F_IDX_W-1:0]     o_winner_index,
    output logic [lpnl_pkg::F_LEN_W-1:0]     o_matched_length
);

    logic                              wr_en;
    logic [lpnl_pkg::IDX_W-1:0]        wr_addr;
    logic [lpnl_pkg::ENTRY_W-1:0]      wr_data;
    logic [lpnl_pkg::ENTRY_W-1:0]      rd_data;
    logic [lpnl_pkg::NAME_W-1:0]       e_chars;
    logic [lpnl_pkg::LEN_W-1:0]        e_len;
    logic [lpnl_pkg::VALUE_W-1:0]      e_value;
    logic [lpnl_pkg::LEN_W-1:0]        lim;
    logic [lpnl_pkg::LEN_W-1:0]        cnt;

    logic [lpnl_pkg::NAME_W-1:0]       r_q_chars;
    logic [lpnl_pkg::LEN_W-1:0]        r_q_len;
    logic [lpnl_pkg::LEN_W-1:0]        r_best_len;
    logic [lpnl_pkg::IDX_W-1:0]        r_best_idx;
    logic [lpnl_pkg::VALUE_W-1:0]      r_best_value;
    logic                              r_o_found;
    logic [lpnl_pkg::VALUE_W-1:0]      r_o_value;
    logic [lpnl_pkg::F_IDX_W-1:0]      r_o_idx;
    logic [lpnl_pkg::F_LEN_W-1:0]      r_o_len;

    assign wr_en   = i_cmd.load_wr && (int'(i_entry_index) < lpnl_pkg::TABLE_DEPTH);
    assign wr_addr = lpnl_pkg::IDX_W'(i_entry_index);
    assign wr_data = {i_value_bits, lpnl_pkg::clamp_len(i_name_length),
                      lpnl_pkg::NAME_W'(i_name_chars)};

    lpnl_ram #(
        .WIDTH (lpnl_pkg::ENTRY_W),
        .DEPTH (lpnl_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_data)
    );

    assign e_chars = rd_data[lpnl_pkg::NAME_W-1:0];
    assign e_len   = rd_data[lpnl_pkg::NAME_W +: lpnl_pkg::LEN_W];
    assign e_value = rd_data[lpnl_pkg::NAME_W + lpnl_pkg::LEN_W +: lpnl_pkg::VALUE_W];
    assign lim     = (r_q_len < e_len) ? r_q_len : e_len;
    assign cnt     = lpnl_pkg::prefix_len(r_q_chars, e_chars, lim);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q_chars    <= lpnl_pkg::NAME_W'(i_name_chars);
            r_q_len      <= lpnl_pkg::clamp_len(i_name_length);
            r_best_len   <= '0;
            r_best_idx   <= '0;
            r_best_value <= '0;
        end else if (i_cmd.cmp_en && (cnt > r_best_len)) begin
            r_best_len   <= cnt;
            r_best_idx   <= i_cmd.cmp_idx;
            r_best_value <= e_value;
        end
        if (i_cmd.out_load) begin
            r_o_found <= (r_best_len != '0);
            r_o_value <= r_best_value;
            r_o_idx   <= lpnl_pkg::F_IDX_W'(r_best_idx);
            r_o_len   <= lpnl_pkg::F_LEN_W'(r_best_len);
        end
    end

    assign o_found          = r_o_found;
    assign o_value_out      = r_o_value;
    assign o_winner_index   = r_o_idx;
    assign o_matched_length = r_o_len;

endmodule

// ===== rtl/lpnl_ctrl.sv =====
// Controller of the name lookup: handshakes, configuration register and table scan sequencing.
module lpnl_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lpnl_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_op,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output lpnl_pkg::t_cmd               o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_HOLD
    } t_state;

    t_state                          r_state, n_state;
    logic [lpnl_pkg::CFG_W-1:0]      r_cfg;
    logic [lpnl_pkg::IDX_W-1:0]      r_addr, n_addr;
    logic [lpnl_pkg::IDX_W-1:0]      r_last, n_last;
    logic                            r_cmp_v;
    logic [lpnl_pkg::IDX_W-1:0]      r_cmp_idx;
    logic                            r_out_valid, n_out_valid;
    logic [lpnl_pkg::CNT_W-1:0]      count;
    logic                            in_acc;

    assign count = (int'(r_cfg) > lpnl_pkg::TABLE_DEPTH) ?
                   lpnl_pkg::CNT_W'(lpnl_pkg::TABLE_DEPTH) : lpnl_pkg::CNT_W'(r_cfg);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd          = '0;
        o_cmd.rd_addr  = r_addr;
        o_cmd.cmp_en   = r_cmp_v;
        o_cmd.cmp_idx  = r_cmp_idx;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_op == lpnl_pkg::OP_LOOKUP) begin
                        o_cmd.start = 1'b1;
                        n_addr      = '0;
                        n_last      = lpnl_pkg::IDX_W'(count - lpnl_pkg::CNT_W'(1));
                        n_state     = (count == '0) ? S_HOLD : S_SCAN;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + lpnl_pkg::IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_v     <= (r_state == S_SCAN);
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
        r_addr    <= n_addr;
        r_last    <= n_last;
        r_cmp_idx <= r_addr;
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_last))
        else $error("Scan address ran past the last entry.");

    a_cmp_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_v |-> ($past(r_state == S_SCAN) && (r_cmp_idx == $past(r_addr))))
        else $error("Compare without a matching table read.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("Result register overwritten before its transaction.");

    a_lookup_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_op == lpnl_pkg::OP_LOOKUP && r_cfg != '0) |=> (r_state == S_SCAN))
        else $error("Lookup with entries in use did not start a scan.");
`endif

endmodule

// ===== rtl/longest_prefix_name_lookup.sv =====
// Top level of the longest-prefix name lookup block.
//
//   Channel   Direction  Transaction
//   i_req     in         load one table entry or look up a query name
//   o_rsp     out        one result for each lookup
//   i_cfg_*   in         write of the entries_in_use register
//
// A load is written to the table in the cycle it is accepted. A lookup scans the first
// min(entries_in_use, 64) entries before the block is ready again, one table entry per cycle
// through the single read port of the entry RAM; with no entry in use it skips the scan.
// The result is held in an output register, so a new transaction is accepted while
// it waits. Reset is synchronous and active low and clears control state only;
// table entries are undefined until loaded.
// A stalled result holds the scanner until the output register frees.
module longest_prefix_name_lookup (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lpnl_pkg::CFG_W-1:0]   i_cfg_wdata,
    lpnl_req_if.sink                     i_req,
    lpnl_rsp_if.source                   o_rsp
);

    lpnl_pkg::t_cmd cmd;

    lpnl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_req.valid),
        .i_in_op     (i_req.operation),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    lpnl_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_entry_index    (i_req.entry_index),
        .i_name_chars     (i_req.name_chars),
        .i_name_length    (i_req.name_length),
        .i_value_bits     (i_req.value_bits),
        .o_found          (o_rsp.found),
        .o_value_out      (o_rsp.value_out),
        .o_winner_index   (o_rsp.winner_index),
        .o_matched_length (o_rsp.matched_length)
    );

endmodule
